[hdl/assert_macros.svh]
// Assertion macros for the line-start index block.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define LSIL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LSIL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/lsil_pkg.sv]
// Package for the line-start index and lookup block.
// Sizes, codes, state machine type and controller/datapath command structs.
package lsil_pkg;

   localparam int MAX_LINES = 4096;
   localparam int POS_BITS  = 24;
   localparam int IDX_BITS  = $clog2(MAX_LINES);
   localparam int CNT_BITS  = $clog2(MAX_LINES + 1);

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum logic [1:0] {
      REQ_BYTE  = 2'd0,
      REQ_END   = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      BRK_NONE = 2'd0,
      BRK_CR   = 2'd1,
      BRK_LF   = 2'd2
   } brk_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_NOT_DONE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_END2,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic end_push;
      logic end_close;
      logic query_start;
      logic srch_read;
      logic srch_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic table_done;
      logic extra_push;
      logic search_done;
      logic rsp_free;
   } stat_type;

endpackage

[hdl/lsil_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on lsil_pkg for field widths.
interface lsil_req_if;
   import lsil_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [7:0]          data_byte;
   logic [POS_BITS-1:0] query_pos;

   modport source (output valid, req_type, data_byte, query_pos, input ready);
   modport sink   (input valid, req_type, data_byte, query_pos, output ready);
endinterface

interface lsil_rsp_if;
   import lsil_pkg::*;
   logic                valid;
   logic                ready;
   logic [CNT_BITS-1:0] line_number;
   logic [1:0]          status;

   modport source (output valid, line_number, status, input ready);
   modport sink   (input valid, line_number, status, output ready);
endinterface

[hdl/line_start_index_and_lookup.sv]
// Line-start index builder with line-number lookup. Buffer bytes go in one per
// item; an end-of-buffer item passes through the extra state S_END2 when a line
// break is still open or it is the first item of the buffer, to push one more entry.
// A line query before end of buffer answers with status "not finished".
// After end of buffer a query runs a binary search over the line table memory,
// each probe a read state and then a compare state, then a state that sees the
// bounds meet and a load of the result; a result register still held by the
// receiver stalls that load. Byte items are accepted while a query result
// waits to be taken. The table needs no clearing pass after reset.
// Depends on lsil_pkg, lsil_if, lsil_ctrl, lsil_dpath.
module line_start_index_and_lookup (
   input  logic        clock,
   input  logic        reset,
   lsil_req_if.sink    req_ch,
   lsil_rsp_if.source  rsp_ch
);
   import lsil_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lsil_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .stat   (stat),
      .cmd    (cmd)
   );

   lsil_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_ch.data_byte),
      .query_pos (req_ch.query_pos),
      .stat      (stat),
      .rsp_ch    (rsp_ch)
   );

endmodule

[hdl/lsil_ctrl.sv]
// Controller FSM: decodes requests and sequences pushes and the binary search.
// Depends on lsil_pkg and lsil_req_if.
module lsil_ctrl (
   input  logic                clock,
   input  logic                reset,
   lsil_req_if.sink            req_ch,
   input  lsil_pkg::stat_type  stat,
   output lsil_pkg::cmd_type   cmd
);
   import lsil_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // nothing is taken while reset is held
            req_ch.ready = !reset;
            if (req_ch.valid && req_ch.ready) begin
               unique case (req_ch.req_type)
                  REQ_BYTE: begin
                     cmd.take_byte = !stat.table_done;
                  end
                  REQ_END: begin
                     if (!stat.table_done) begin
                        // first item of the buffer, or a break still open
                        if (stat.extra_push) begin
                           cmd.end_push = 1'b1;
                           state_in     = S_END2;
                        end else begin
                           cmd.end_close = 1'b1;
                        end
                     end
                  end
                  REQ_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = stat.table_done ? S_SRCH_RD : S_RESP;
                  end
                  default: ;
               endcase
            end
         end
         S_END2: begin
            cmd.end_close = 1'b1;
            state_in      = S_IDLE;
         end
         S_SRCH_RD: begin
            if (stat.search_done) begin
               state_in = S_RESP;
            end else begin
               cmd.srch_read = 1'b1;
               state_in      = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SRCH_RD;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/lsil_dpath.sv]
// Datapath: line-start table memory, offset tracking, search bounds, result register.
// Depends on lsil_pkg, lsil_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module lsil_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  lsil_pkg::cmd_type             cmd,
   input  logic [7:0]                    data_byte,
   input  logic [lsil_pkg::POS_BITS-1:0] query_pos,
   output lsil_pkg::stat_type            stat,
   lsil_rsp_if.source                    rsp_ch
);
   import lsil_pkg::*;

   logic [POS_BITS-1:0] mem [MAX_LINES];

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [POS_BITS-1:0] off_ff, off_in;
   brk_type             pend_ff, pend_in;
   logic                done_ff, done_in;
   logic                ovf_ff, ovf_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] lo_ff, lo_in;
   logic [CNT_BITS-1:0] hi_ff, hi_in;
   logic [POS_BITS-1:0] rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0] rsp_line_ff;
   status_type          rsp_status_ff;

   logic                push_en;
   logic [POS_BITS-1:0] push_val;
   logic                wr_en;
   logic                off_sat;
   logic [POS_BITS-1:0] off_inc;
   logic                partner;
   logic [CNT_BITS:0]   mid_sum;
   logic [CNT_BITS-1:0] mid;

   assign off_sat = (off_ff == POS_MAX);
   assign off_inc = off_sat ? off_ff : off_ff + POS_BITS'(1);
   assign partner = ((pend_ff == BRK_CR) && (data_byte == CH_LF)) ||
                    ((pend_ff == BRK_LF) && (data_byte == CH_CR));
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_BITS:1];

   always_comb begin
      cnt_in   = cnt_ff;
      off_in   = off_ff;
      pend_in  = pend_ff;
      done_in  = done_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      push_en  = 1'b0;
      push_val = off_ff;
      wr_en    = 1'b0;

      if (cmd.take_byte) begin
         // opening entry 0 goes in with the first byte
         if (cnt_ff == '0) begin
            push_en = 1'b1;
         end
         if ((pend_ff != BRK_NONE) && partner) begin
            // second half of CRLF or LFCR: line starts after it
            off_in   = off_inc;
            ovf_in   = ovf_ff | off_sat;
            push_en  = 1'b1;
            push_val = off_inc;
            pend_in  = BRK_NONE;
         end else begin
            if (pend_ff != BRK_NONE) begin
               push_en = 1'b1;
            end
            off_in = off_inc;
            ovf_in = ovf_ff | off_sat;
            if (data_byte == CH_CR) begin
               pend_in = BRK_CR;
            end else if (data_byte == CH_LF) begin
               pend_in = BRK_LF;
            end else begin
               pend_in = BRK_NONE;
            end
         end
      end

      if (cmd.end_push) begin
         push_en = 1'b1;
         pend_in = BRK_NONE;
      end

      if (cmd.end_close) begin
         push_en = 1'b1;
         pend_in = BRK_NONE;
         done_in = 1'b1;
      end

      if (push_en) begin
         if (cnt_ff == CNT_BITS'(MAX_LINES)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
      end

      if (cmd.query_start) begin
         pos_in = query_pos;
         lo_in  = '0;
         hi_in  = cnt_ff;
      end

      // upper-bound search: lo ends at the count of entries <= pos
      if (cmd.srch_step) begin
         if (rd_ff <= pos_ff) begin
            lo_in = mid + CNT_BITS'(1);
         end else begin
            hi_in = mid;
         end
      end
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         off_ff       <= '0;
         pend_ff      <= BRK_NONE;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
         pend_ff      <= pend_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.rsp_load) begin
         rsp_line_ff   <= done_ff ? lo_ff : '0;
         rsp_status_ff <= !done_ff ? ST_NOT_DONE : (ovf_ff ? ST_OVERFLOW : ST_OK);
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[IDX_BITS-1:0]] <= push_val;
      end
      if (cmd.srch_read) begin
         rd_ff <= mem[mid[IDX_BITS-1:0]];
      end
   end

   assign stat.table_done  = done_ff;
   assign stat.extra_push  = (cnt_ff == '0) || (pend_ff != BRK_NONE);
   assign stat.search_done = (lo_ff == hi_ff);
   assign stat.rsp_free    = ~rsp_valid_ff | rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.line_number = rsp_line_ff;
   assign rsp_ch.status      = rsp_status_ff;

   `LSIL_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_BITS'(MAX_LINES), "entry count past table size")
   `LSIL_ASSERT(a_search_order, clock, reset, lo_ff <= hi_ff, "search bounds crossed")
   `LSIL_ASSERT_NEXT(a_done_frozen, clock, reset, done_ff, $stable(cnt_ff) && $stable(off_ff), "table changed after end of buffer")
   `LSIL_ASSERT_NEXT(a_ovf_sticky, clock, reset, ovf_ff, ovf_ff, "overflow status cleared")

endmodule

[tb/tb_line_start_index_and_lookup.sv]
`timescale 1ns / 100ps
// Testbench for line_start_index_and_lookup: streams one text buffer amid queries,
// closes it, queries again and checks every result against a local table model.
// Depends on lsil_pkg, lsil_if and the RTL top level.
module tb_line_start_index_and_lookup;
   import lsil_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int LONG_HOLD     = 300;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      logic [1:0]          kind;
      logic [7:0]          byte_val;
      logic [POS_BITS-1:0] pos;
      bit                  drain_first;
      bit                  hold_rsp;
   } buf_item_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] line_no;
      status_type          stat;
   } line_answer_type;

   logic clock;
   logic reset;

   lsil_req_if req_ch ();
   lsil_rsp_if rsp_ch ();

   line_start_index_and_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   buf_item_type    item_queue[$];
   line_answer_type expected_lines[$];
   buf_item_type    on_wire;

   // table model
   logic [POS_BITS-1:0] line_starts [MAX_LINES];
   int                  n_starts;
   logic [POS_BITS-1:0] next_off;
   brk_type             open_brk;
   bit                  buf_closed;
   bit                  tbl_ovf;

   int n_fail;
   int n_checked;
   int n_accepted;
   int n_early_queries;
   int buf_len;
   int hold_asks;
   int hold_served;

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic logic [POS_BITS-1:0] rand_pos();
      return POS_BITS'($urandom_range(POS_MAX, 0));
   endfunction

   task automatic add_start(input logic [POS_BITS-1:0] v);
      if (n_starts >= MAX_LINES) begin
         tbl_ovf = 1'b1;
      end else begin
         line_starts[n_starts] = v;
         n_starts++;
      end
   endtask

   task automatic bump_off();
      if (next_off == POS_MAX) begin
         tbl_ovf = 1'b1;
      end else begin
         next_off++;
      end
   endtask

   task automatic index_item(input buf_item_type it);
      int  cnt;
      bit  partner;
      line_answer_type ans;
      case (it.kind) inside
         REQ_BYTE, REQ_END: begin
            if (!buf_closed) begin
               if (n_starts == 0) add_start('0);
               if (it.kind == REQ_BYTE) begin
                  partner = (open_brk == BRK_CR && it.byte_val == CH_LF) ||
                            (open_brk == BRK_LF && it.byte_val == CH_CR);
                  if (open_brk != BRK_NONE && partner) begin
                     // second half of a CRLF / LFCR pair: one break only
                     bump_off();
                     add_start(next_off);
                     open_brk = BRK_NONE;
                  end else begin
                     if (open_brk != BRK_NONE) begin
                        add_start(next_off);
                        open_brk = BRK_NONE;
                     end
                     bump_off();
                     if (it.byte_val == CH_CR)      open_brk = BRK_CR;
                     else if (it.byte_val == CH_LF) open_brk = BRK_LF;
                  end
               end else begin
                  if (open_brk != BRK_NONE) begin
                     add_start(next_off);
                     open_brk = BRK_NONE;
                  end
                  add_start(next_off);
                  buf_closed = 1'b1;
               end
            end
         end
         REQ_QUERY: begin
            cnt = 0;
            if (!buf_closed) begin
               ans.stat = ST_NOT_DONE;
               n_early_queries++;
            end else begin
               for (int i = 0; i < n_starts; i++)
                  if (line_starts[i] <= it.pos) cnt++;
               ans.stat = tbl_ovf ? ST_OVERFLOW : ST_OK;
            end
            ans.line_no = cnt[CNT_BITS-1:0];
            expected_lines = {expected_lines, ans};
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [1:0] kind, input logic [7:0] b,
                            input logic [POS_BITS-1:0] p, input bit drain, input bit hold);
      buf_item_type it;
      it.kind        = kind;
      it.byte_val    = b;
      it.pos         = p;
      it.drain_first = drain;
      it.hold_rsp    = hold;
      item_queue = {item_queue, it};
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_item(REQ_BYTE, b, rand_pos(), 1'b0, 1'b0);
      buf_len++;
   endtask

   task automatic push_query(input logic [POS_BITS-1:0] p, input bit drain, input bit hold);
      push_item(REQ_QUERY, rand_byte(0, 255), p, drain, hold);
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      int tx_gap;
      int tx_calm;
      int r;
      if (reset) begin
         req_ch.valid <= 1'b0;
         tx_gap = 0;
         tx_calm = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            index_item(on_wire);
            n_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_ch.valid <= 1'b0;
            end else if (item_queue.size() != 0 &&
                         !(item_queue[0].drain_first && expected_lines.size() != 0)) begin
               on_wire = item_queue.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.req_type  <= on_wire.kind;
               req_ch.data_byte <= on_wire.byte_val;
               req_ch.query_pos <= on_wire.pos;
               if (on_wire.hold_rsp) hold_asks++;
               if (tx_calm > 0) begin
                  tx_calm--;
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 25)      tx_gap = $urandom_range(1, 3);
                  else if (r < 28) tx_gap = $urandom_range(10, 40);
                  else if (r < 31) tx_calm = $urandom_range(30, 120);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: random back-pressure plus the requested long hold
   always @(posedge clock) begin : rsp_receiver
      int hold_left;
      int rx_gap;
      int rx_calm;
      int r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
         rx_gap = 0;
         rx_calm = 0;
      end else begin
         if (hold_asks != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rx_calm > 0) begin
               rx_calm--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 30)      rx_gap = $urandom_range(1, 3);
               else if (r < 33) rx_gap = $urandom_range(10, 50);
               else if (r < 36) rx_calm = $urandom_range(50, 200);
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      line_answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_lines.size() == 0) begin
            $error("unexpected result: line_number %0d status %0d",
                   rsp_ch.line_number, rsp_ch.status);
            n_fail++;
         end else begin
            want = expected_lines.pop_front();
            n_checked++;
            if (rsp_ch.line_number !== want.line_no) begin
               $error("line_number: expected %0d, got %0d", want.line_no, rsp_ch.line_number);
               n_fail++;
            end
            if (rsp_ch.status !== want.stat) begin
               $error("status: expected %0d, got %0d", want.stat, rsp_ch.status);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int idle;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= WATCHDOG_MAX) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_MAX);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] opening [12] = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_LF, CH_CR,
                                   CH_CR, CH_CR, CH_LF, CH_LF, 8'h61, CH_CR};
      int r;
      logic [POS_BITS-1:0] p;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_BYTE;
      req_ch.data_byte = '0;
      req_ch.query_pos = '0;
      rsp_ch.ready     = 1'b0;
      n_starts   = 0;
      next_off   = '0;
      open_brk   = BRK_NONE;
      buf_closed = 1'b0;
      tbl_ovf    = 1'b0;

      // directed opening: empty-table query, unused code, NUL/0xFF, all break pairs
      push_query('0, 1'b0, 1'b0);
      push_item(REQ_UNUSED, 8'hFF, 24'hFFFFFF, 1'b0, 1'b0);
      foreach (opening[i]) push_byte(opening[i]);
      push_query(POS_MAX, 1'b0, 1'b0);

      // random text, with early queries answering "not finished"
      for (int k = 0; k < 560; k++) begin
         r = $urandom_range(0, 99);
         if (k == 100) begin
            push_query(rand_pos(), 1'b0, 1'b1);
            repeat (6) push_query(rand_pos(), 1'b0, 1'b0);
         end else if (r < 7) begin
            push_query(rand_pos(), 1'b0, 1'b0);
         end else if (r < 9) begin
            push_item(REQ_UNUSED, rand_byte(0, 255), rand_pos(), 1'b0, 1'b0);
         end else if (r < 55) begin
            push_byte(rand_byte(32, 126));
         end else if (r < 68) begin
            push_byte(CH_LF);
         end else if (r < 80) begin
            push_byte(CH_CR);
         end else if (r < 85) begin
            push_byte(8'h00);
         end else begin
            push_byte(rand_byte(0, 255));
         end
      end

      // close the buffer with a break still open; wait for results first
      push_byte(CH_CR);
      push_item(REQ_END, rand_byte(0, 255), rand_pos(), 1'b1, 1'b0);

      push_query('0, 1'b0, 1'b0);
      push_query(POS_MAX, 1'b0, 1'b0);
      push_query(POS_BITS'(buf_len), 1'b0, 1'b0);
      push_query(POS_BITS'(buf_len - 1), 1'b0, 1'b0);
      push_query(POS_BITS'(buf_len + 1), 1'b0, 1'b0);
      push_query(24'd1, 1'b0, 1'b0);
      // items after the end are ignored
      push_item(REQ_BYTE, CH_LF, 24'h000000, 1'b0, 1'b0);
      push_item(REQ_END, 8'h00, 24'hFFFFFF, 1'b0, 1'b0);
      push_item(REQ_UNUSED, 8'hAA, 24'h555555, 1'b0, 1'b0);

      for (int k = 0; k < 270; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35)      p = POS_BITS'($urandom_range(buf_len + 1, 0));
         else if (r < 55) p = POS_BITS'($urandom_range(40, 0));
         else if (r < 75) p = POS_BITS'(buf_len - 2 + $urandom_range(4, 0));
         else             p = rand_pos();
         if ($urandom_range(0, 99) < 5) begin
            push_item($urandom_range(0, 1) ? REQ_END : REQ_BYTE, rand_byte(0, 255),
                      rand_pos(), 1'b0, 1'b0);
         end
         push_query(p, k == 150, k == 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (item_queue.size() != 0 || req_ch.valid || expected_lines.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_lines.size() != 0) begin
         $error("%0d expected results never arrived", expected_lines.size());
         n_fail++;
      end

      $display("Run: %0d items accepted, %0d-byte buffer, %0d results checked (%0d before end).",
               n_accepted, buf_len, n_checked, n_early_queries);
      $display("Line table held %0d entries; %s.", n_starts,
               tbl_ovf ? "capacity exceeded" : "within capacity");
      if (n_fail == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[line_start_index_and_lookup.f]
+incdir+hdl
hdl/lsil_pkg.sv
hdl/lsil_if.sv
hdl/lsil_ctrl.sv
hdl/lsil_dpath.sv
hdl/line_start_index_and_lookup.sv
tb/tb_line_start_index_and_lookup.sv
